// ===== src/tprs_pkg.sv =====
// tprs_pkg: shared types and constants for the touch point rotate/scale block.
// No dependencies.
`default_nettype none

package tprs_pkg;

  // Width of one mapped coordinate on the result channel
  localparam int OUT_W      = 26;
  // Result tdata: mapped_x, mapped_y packed and padded to whole bytes
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE_X        = 3'd0,
    REG_BASE_Y        = 3'd1,
    REG_WIN_WIDTH     = 3'd2,
    REG_WIN_HEIGHT    = 3'd3,
    REG_TARGET_WIDTH  = 3'd4,
    REG_TARGET_HEIGHT = 3'd5,
    REG_QUARTER_TURNS = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  // Per-request control carried alongside the divider data
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic zero_x;
    logic zero_y;
  } tprs_ctl_t;

endpackage

`default_nettype wire

// ===== src/tprs_front.sv =====
// tprs_front: window offset, quarter-turn selection and scale multiply.
// Two register stages ahead of the divider chain. Uses tprs_pkg.
`default_nettype none

module tprs_front
  import tprs_pkg::*;
#(
  parameter int C = 12,
  parameter int N = 2 * C + 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [C-1:0] point_x,
  input  wire logic [C-1:0] point_y,
  input  wire logic [C-1:0] base_x,
  input  wire logic [C-1:0] base_y,
  input  wire logic [C-1:0] win_width,
  input  wire logic [C-1:0] win_height,
  input  wire logic [C-1:0] target_width,
  input  wire logic [C-1:0] target_height,
  input  wire rot_t         quarter_turns,
  output tprs_ctl_t         ctl_o,
  output logic [N-1:0]      prod_x_o,
  output logic [N-1:0]      prod_y_o,
  output logic [C-1:0]      den_x_o,
  output logic [C-1:0]      den_y_o
);

  // stage A: signed offsets and divisor choice
  logic                signed [C+1:0] dx, dy, vwdx, vhdy;
  logic                signed [C+1:0] a_off_x_nxt, a_off_y_nxt;
  logic [C-1:0]        a_den_x_nxt, a_den_y_nxt;
  logic                a_valid_r;
  logic signed [C+1:0] a_off_x_r, a_off_y_r;
  logic [C-1:0]        a_den_x_r, a_den_y_r, a_num_x_r, a_num_y_r;

  // stage B: magnitude times numerator
  logic [C+1:0]        abs_x, abs_y;
  logic [N-1:0]        b_prod_x_nxt, b_prod_y_nxt;
  tprs_ctl_t           b_ctl_nxt, b_ctl_r;
  logic [N-1:0]        b_prod_x_r, b_prod_y_r;
  logic [C-1:0]        b_den_x_r, b_den_y_r;

  always_comb begin
    dx   = $signed({2'b00, point_x}) - $signed({2'b00, base_x});
    dy   = $signed({2'b00, point_y}) - $signed({2'b00, base_y});
    vwdx = $signed({2'b00, win_width}) - dx;
    vhdy = $signed({2'b00, win_height}) - dy;
    unique case (quarter_turns)
      ROT_0: begin
        a_off_x_nxt = dx;    a_den_x_nxt = win_width;
        a_off_y_nxt = dy;    a_den_y_nxt = win_height;
      end
      ROT_90: begin
        a_off_x_nxt = dy;    a_den_x_nxt = win_height;
        a_off_y_nxt = vwdx;  a_den_y_nxt = win_width;
      end
      ROT_180: begin
        a_off_x_nxt = vwdx;  a_den_x_nxt = win_width;
        a_off_y_nxt = vhdy;  a_den_y_nxt = win_height;
      end
      default: begin
        a_off_x_nxt = vhdy;  a_den_x_nxt = win_height;
        a_off_y_nxt = dx;    a_den_y_nxt = win_width;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_off_x_r <= a_off_x_nxt;
      a_off_y_r <= a_off_y_nxt;
      a_den_x_r <= a_den_x_nxt;
      a_den_y_r <= a_den_y_nxt;
      a_num_x_r <= target_width;
      a_num_y_r <= target_height;
    end
  end

  // magnitude fits C+1 bits, so the product fits N = 2C+1 bits
  always_comb begin
    abs_x = a_off_x_r[C+1] ? (C+2)'(0) - a_off_x_r : a_off_x_r;
    abs_y = a_off_y_r[C+1] ? (C+2)'(0) - a_off_y_r : a_off_y_r;
    b_prod_x_nxt     = N'(abs_x[C:0]) * N'(a_num_x_r);
    b_prod_y_nxt     = N'(abs_y[C:0]) * N'(a_num_y_r);
    b_ctl_nxt.valid  = a_valid_r;
    b_ctl_nxt.neg_x  = a_off_x_r[C+1];
    b_ctl_nxt.neg_y  = a_off_y_r[C+1];
    b_ctl_nxt.zero_x = (a_den_x_r == '0);
    b_ctl_nxt.zero_y = (a_den_y_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else if (en) begin
      b_ctl_r <= b_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod_x_r <= b_prod_x_nxt;
      b_prod_y_r <= b_prod_y_nxt;
      b_den_x_r  <= a_den_x_r;
      b_den_y_r  <= a_den_y_r;
    end
  end

  assign ctl_o    = b_ctl_r;
  assign prod_x_o = b_prod_x_r;
  assign prod_y_o = b_prod_y_r;
  assign den_x_o  = b_den_x_r;
  assign den_y_o  = b_den_y_r;

endmodule

`default_nettype wire

// ===== src/tprs_div_cell.sv =====
// tprs_div_cell: one restoring division step for both axes, registered.
// N of these in a row yield the quotient bits MSB first. Uses tprs_pkg.
`default_nettype none

module tprs_div_cell
  import tprs_pkg::*;
#(
  parameter int C = 12,
  parameter int N = 2 * C + 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire tprs_ctl_t    ctl_i,
  input  wire logic [C-1:0] rem_x_i,
  input  wire logic [N-1:0] dq_x_i,
  input  wire logic [C-1:0] den_x_i,
  input  wire logic [C-1:0] rem_y_i,
  input  wire logic [N-1:0] dq_y_i,
  input  wire logic [C-1:0] den_y_i,
  output tprs_ctl_t         ctl_o,
  output logic [C-1:0]      rem_x_o,
  output logic [N-1:0]      dq_x_o,
  output logic [C-1:0]      den_x_o,
  output logic [C-1:0]      rem_y_o,
  output logic [N-1:0]      dq_y_o,
  output logic [C-1:0]      den_y_o
);

  // dq holds the unconsumed dividend bits on top, quotient bits below
  logic [C:0]   t_x, t_y, d_x, d_y;
  logic         ge_x, ge_y;
  logic [C-1:0] rem_x_nxt, rem_y_nxt;
  logic [N-1:0] dq_x_nxt, dq_y_nxt;
  tprs_ctl_t    ctl_r;
  logic [C-1:0] rem_x_r, rem_y_r, den_x_r, den_y_r;
  logic [N-1:0] dq_x_r, dq_y_r;

  always_comb begin
    t_x  = {rem_x_i, dq_x_i[N-1]};
    t_y  = {rem_y_i, dq_y_i[N-1]};
    ge_x = (t_x >= {1'b0, den_x_i});
    ge_y = (t_y >= {1'b0, den_y_i});
    d_x  = t_x - {1'b0, den_x_i};
    d_y  = t_y - {1'b0, den_y_i};
    rem_x_nxt = ge_x ? d_x[C-1:0] : t_x[C-1:0];
    rem_y_nxt = ge_y ? d_y[C-1:0] : t_y[C-1:0];
    dq_x_nxt  = {dq_x_i[N-2:0], ge_x};
    dq_y_nxt  = {dq_y_i[N-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      dq_x_r  <= dq_x_nxt;
      dq_y_r  <= dq_y_nxt;
      den_x_r <= den_x_i;
      den_y_r <= den_y_i;
    end
  end

  assign ctl_o   = ctl_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign dq_x_o  = dq_x_r;
  assign dq_y_o  = dq_y_r;
  assign den_x_o = den_x_r;
  assign den_y_o = den_y_r;

endmodule

`default_nettype wire

// ===== src/tprs_out_buf.sv =====
// tprs_out_buf: sign restore, wrap to the output width, output register and skid.
// Its ready is registered and stalls the whole chain. Uses tprs_pkg.
`default_nettype none

module tprs_out_buf
  import tprs_pkg::*;
#(
  parameter int N = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tprs_ctl_t             ctl_i,
  input  wire logic [N-1:0]          q_x_i,
  input  wire logic [N-1:0]          q_y_i,
  output logic                       ready_o,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int RW = (N + 1 > OUT_W) ? N + 1 : OUT_W;

  logic signed [N:0]    sq_x, sq_y;
  logic signed [RW-1:0] ext_x, ext_y;
  logic [2*OUT_W-1:0]   res;
  logic                 push, pop;
  logic                 out_valid_r, skid_valid_r;
  logic [2*OUT_W-1:0]   out_data_r, skid_data_r;

  always_comb begin
    sq_x = ctl_i.neg_x ? -$signed({1'b0, q_x_i}) : $signed({1'b0, q_x_i});
    sq_y = ctl_i.neg_y ? -$signed({1'b0, q_y_i}) : $signed({1'b0, q_y_i});
    if (ctl_i.zero_x) sq_x = '0;
    if (ctl_i.zero_y) sq_y = '0;
    ext_x = RW'(sq_x);
    ext_y = RW'(sq_y);
    res   = {ext_y[OUT_W-1:0], ext_x[OUT_W-1:0]};
  end

  assign ready_o = !skid_valid_r;
  assign push    = ready_o && ctl_i.valid;
  assign pop     = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*OUT_W){1'b0}}, out_data_r};

endmodule

`default_nettype wire

// ===== src/touch_point_rotate_scale.sv =====
// touch_point_rotate_scale: top level; config registers, front stages,
// divider cell row and output buffer. Uses tprs_pkg and the tprs_* modules.
//
//  channel | direction | handshake            | payload
//  in_     | request   | in_tvalid/in_tready  | in_tdata: point_x, point_y
//  out_    | result    | out_tvalid/out_tready| out_tdata: mapped_x, mapped_y
//  cfg_    | write     | cfg_wen              | cfg_addr, cfg_wdata
//
// One request per cycle while in_tready is high. Each request passes through two
// front stages, one divider cell per quotient bit, and the output register,
// which then raises out_tvalid.
// Synchronous active-low reset clears valids and loads register defaults.
// A stalled output fills the skid stage, then in_tready drops and the whole
// row of cells holds until the output register drains.
`default_nettype none

module touch_point_rotate_scale
  import tprs_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [COORD_BITS-1:0] point_x, [2*COORD_BITS-1:COORD_BITS] point_y, zero pad
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [25:0] mapped_x, [51:26] mapped_y, zero pad
  output logic [OUT_DATA_W-1:0]            out_tdata,
  input  wire logic                        cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [COORD_BITS-1:0]       cfg_wdata
);

  localparam int C = COORD_BITS;
  localparam int N = 2 * C + 1;

  logic [C-1:0] base_x_r, base_y_r, win_width_r, win_height_r;
  logic [C-1:0] target_width_r, target_height_r;
  rot_t         quarter_turns_r;
  logic         en;

  tprs_ctl_t    ctl   [0:N];
  logic [C-1:0] rem_x [0:N];
  logic [C-1:0] rem_y [0:N];
  logic [N-1:0] dq_x  [0:N];
  logic [N-1:0] dq_y  [0:N];
  logic [C-1:0] den_x [0:N];
  logic [C-1:0] den_y [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r        <= '0;
      base_y_r        <= '0;
      win_width_r     <= C'(1280);
      win_height_r    <= C'(800);
      target_width_r  <= C'(1200);
      target_height_r <= C'(1600);
      quarter_turns_r <= ROT_90;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BASE_X:        base_x_r        <= cfg_wdata;
        REG_BASE_Y:        base_y_r        <= cfg_wdata;
        REG_WIN_WIDTH:     win_width_r     <= cfg_wdata;
        REG_WIN_HEIGHT:    win_height_r    <= cfg_wdata;
        REG_TARGET_WIDTH:  target_width_r  <= cfg_wdata;
        REG_TARGET_HEIGHT: target_height_r <= cfg_wdata;
        REG_QUARTER_TURNS: quarter_turns_r <= rot_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  assign in_tready = en;

  tprs_front #(.C(C), .N(N)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_tvalid),
    .point_x       (in_tdata[C-1:0]),
    .point_y       (in_tdata[2*C-1:C]),
    .base_x        (base_x_r),
    .base_y        (base_y_r),
    .win_width     (win_width_r),
    .win_height    (win_height_r),
    .target_width  (target_width_r),
    .target_height (target_height_r),
    .quarter_turns (quarter_turns_r),
    .ctl_o         (ctl[0]),
    .prod_x_o      (dq_x[0]),
    .prod_y_o      (dq_y[0]),
    .den_x_o       (den_x[0]),
    .den_y_o       (den_y[0])
  );

  assign rem_x[0] = '0;
  assign rem_y[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tprs_div_cell #(.C(C), .N(N)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_i   (ctl[i]),
      .rem_x_i (rem_x[i]),
      .dq_x_i  (dq_x[i]),
      .den_x_i (den_x[i]),
      .rem_y_i (rem_y[i]),
      .dq_y_i  (dq_y[i]),
      .den_y_i (den_y[i]),
      .ctl_o   (ctl[i+1]),
      .rem_x_o (rem_x[i+1]),
      .dq_x_o  (dq_x[i+1]),
      .den_x_o (den_x[i+1]),
      .rem_y_o (rem_y[i+1]),
      .dq_y_o  (dq_y[i+1]),
      .den_y_o (den_y[i+1])
    );
  end

  tprs_out_buf #(.N(N)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl[N]),
    .q_x_i      (dq_x[N]),
    .q_y_i      (dq_y[N]),
    .ready_o    (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== src/tprs_checker.sv =====
// tprs_checker: port-level checks for touch_point_rotate_scale, bound to the top.
// Uses tprs_pkg.
`default_nettype none

module tprs_checker
  import tprs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // input side only blocks when a result is parked at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input blocked with empty output");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("bad state after reset");

endmodule

bind touch_point_rotate_scale tprs_checker u_tprs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/tprs_map_checker.sv =====
`timescale 1ns / 1ps
// tprs_map_checker: watches the point, result and register ports of
// touch_point_rotate_scale, predicts every mapped point and compares it.
// Depends on tprs_pkg.
module tprs_map_checker
  import tprs_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  // [COORD_BITS-1:0] point_x, [2*COORD_BITS-1:COORD_BITS] point_y, zero pad
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  // [25:0] mapped_x, [51:26] mapped_y, zero pad
  input  wire logic [OUT_DATA_W-1:0]             out_tdata,
  input  wire logic                              cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0]             cfg_addr,
  input  wire logic [COORD_BITS-1:0]             cfg_wdata,
  output int                                     mismatches,
  output int                                     maps_in_flight
);

  typedef logic signed [OUT_W-1:0] coord_t;
  typedef struct packed {
    coord_t mapped_y;
    coord_t mapped_x;
  } mapped_t;

  // shadow copy of the view/target registers
  logic [COORD_BITS-1:0] base_x, base_y, view_w, view_h, tgt_w, tgt_h;
  rot_t                  turns;

  mapped_t pending_maps[$];

  function automatic coord_t scale_coord(longint offset, longint num, longint den);
    longint q;
    if (den == 0) return '0;
    // SV signed division truncates toward zero
    q = offset * num / den;
    return q[OUT_W-1:0];
  endfunction

  function automatic mapped_t map_point(logic [COORD_BITS-1:0] px,
                                        logic [COORD_BITS-1:0] py);
    longint  dx, dy, vw, vh, tw, th;
    mapped_t m;
    dx = longint'(px) - longint'(base_x);
    dy = longint'(py) - longint'(base_y);
    vw = longint'(view_w);
    vh = longint'(view_h);
    tw = longint'(tgt_w);
    th = longint'(tgt_h);
    case (turns)
      ROT_0: begin
        m.mapped_x = scale_coord(dx, tw, vw);
        m.mapped_y = scale_coord(dy, th, vh);
      end
      ROT_90: begin
        m.mapped_x = scale_coord(dy, tw, vh);
        m.mapped_y = scale_coord(vw - dx, th, vw);
      end
      ROT_180: begin
        m.mapped_x = scale_coord(vw - dx, tw, vw);
        m.mapped_y = scale_coord(vh - dy, th, vh);
      end
      default: begin
        m.mapped_x = scale_coord(vh - dy, tw, vh);
        m.mapped_y = scale_coord(dx, th, vw);
      end
    endcase
    return m;
  endfunction

  always @(posedge clk) begin
    mapped_t want, got;
    if (!rst_n) begin
      base_x = '0;
      base_y = '0;
      view_w = COORD_BITS'(1280);
      view_h = COORD_BITS'(800);
      tgt_w  = COORD_BITS'(1200);
      tgt_h  = COORD_BITS'(1600);
      turns  = ROT_90;
      pending_maps.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          REG_BASE_X:        base_x = cfg_wdata;
          REG_BASE_Y:        base_y = cfg_wdata;
          REG_WIN_WIDTH:     view_w = cfg_wdata;
          REG_WIN_HEIGHT:    view_h = cfg_wdata;
          REG_TARGET_WIDTH:  tgt_w  = cfg_wdata;
          REG_TARGET_HEIGHT: tgt_h  = cfg_wdata;
          REG_QUARTER_TURNS: turns  = rot_t'(cfg_wdata[1:0]);
          default: ;
        endcase
      end
      // results first: a request taken on this edge cannot leave on it
      if (out_tvalid && out_tready) begin
        got.mapped_x = out_tdata[OUT_W-1:0];
        got.mapped_y = out_tdata[2*OUT_W-1:OUT_W];
        if (pending_maps.size() == 0) begin
          $error("unexpected result: mapped_x %0d, mapped_y %0d",
                 got.mapped_x, got.mapped_y);
          mismatches++;
        end else begin
          want = pending_maps.pop_front();
          if (got.mapped_x !== want.mapped_x) begin
            $error("mapped_x: expected %0d, actual %0d", want.mapped_x, got.mapped_x);
            mismatches++;
          end
          if (got.mapped_y !== want.mapped_y) begin
            $error("mapped_y: expected %0d, actual %0d", want.mapped_y, got.mapped_y);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_maps.push_back(map_point(in_tdata[COORD_BITS-1:0],
                                         in_tdata[2*COORD_BITS-1:COORD_BITS]));
    end
    maps_in_flight = pending_maps.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: drives touch points and register settings into touch_point_rotate_scale
// under several idle/stall mixes; tprs_map_checker does the comparison.
// Depends on tprs_pkg, the block and tprs_map_checker.
module tb;
  import tprs_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int LIMIT      = 200000;
  localparam int PER_SETTING = 96;
  localparam logic [COORD_BITS-1:0] COORD_MAX  = '1;
  localparam logic [COORD_BITS-1:0] COORD_ONE  = 1;
  // no register lives here; writes to it must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_wen    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [COORD_BITS-1:0] cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int maps_in_flight;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  always #6 clk = ~clk;

  touch_point_rotate_scale #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  tprs_map_checker #(.COORD_BITS(COORD_BITS)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .maps_in_flight(maps_in_flight)
  );

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // all driving tasks start and end just after a rising edge
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [COORD_BITS-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by,
                               logic [COORD_BITS-1:0] vw, logic [COORD_BITS-1:0] vh,
                               logic [COORD_BITS-1:0] tw, logic [COORD_BITS-1:0] th,
                               rot_t rot);
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_WIN_WIDTH, vw);
    write_reg(REG_WIN_HEIGHT, vh);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    write_reg(REG_QUARTER_TURNS, COORD_BITS'(rot));
    cfg_wen <= 1'b0;
  endtask

  // leaves in_tvalid high so back-to-back requests need no extra step
  task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({py, px});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (maps_in_flight != 0) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(7))
      0:       return '0;
      1:       return COORD_MAX;
      2:       return COORD_BITS'($urandom_range(1, 16));
      default: return COORD_BITS'($urandom_range(COORD_MAX));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_point();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COORD_MAX;
      default: return COORD_BITS'($urandom_range(COORD_MAX));
    endcase
  endfunction

  initial begin
    int s;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray write, then the reset defaults (90 degrees) must still hold
    write_reg(REG_UNUSED, COORD_MAX);
    cfg_wen <= 1'b0;
    send_point('0, '0);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MAX, '0);
    send_point('0, COORD_MAX);
    drain();

    // each rotation with the base at the corners: negative offsets included
    for (int r = 0; r < 4; r++) begin
      apply_setting(r[0] ? COORD_MAX : '0, r[1] ? COORD_MAX : '0, COORD_MAX, COORD_MAX,
                    r[0] ? COORD_ONE : COORD_MAX, r[0] ? COORD_MAX : COORD_ONE,
                    rot_t'(r));
      send_point('0, '0);
      send_point(COORD_MAX, COORD_MAX);
      drain();
    end

    // zero view size on one axis, unit divisor on the other: largest magnitudes
    for (int r = 0; r < 4; r++) begin
      apply_setting('0, '0, r[0] ? COORD_ONE : '0, r[0] ? '0 : COORD_ONE,
                    COORD_MAX, COORD_MAX, rot_t'(r));
      send_point(COORD_MAX, '0);
      send_point('0, COORD_MAX);
      drain();
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (int k = 0; k < 3; k++) begin
        s = p * 3 + k;
        if (s == 0)
          apply_setting(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        rot_t'(s % 4));
        else if (s == 6)
          apply_setting('0, '0, COORD_ONE, COORD_ONE, COORD_ONE, COORD_ONE,
                        rot_t'(s % 4));
        else
          apply_setting(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), rot_t'(s % 4));
        repeat (PER_SETTING) send_point(pick_point(), pick_point());
        drain();
      end
    end

    // catch anything that leaves after the last expected result
    repeat (40) @(posedge clk);
    if (mismatches == 0 && maps_in_flight == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
